[hw/rtl/sstw_pkg.sv]
`default_nettype none

package sstw_pkg;

    localparam logic [1:0] ACT_CHAR = 2'd0;
    localparam logic [1:0] ACT_END  = 2'd1;
    localparam logic [1:0] ACT_RAW  = 2'd2;

    localparam logic [7:0] CODE_B_MODE = 8'hFF;
    localparam logic [7:0] DP_BIT      = 8'h80;
    localparam logic [7:0] BLANK_CODE_B = 8'h0F;
    localparam logic [7:0] BLANK_SEG    = 8'h00;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_byte;

    function automatic t_byte to_code_b(input t_byte c);
        t_byte v;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else begin
            case (c)
                "-":      v = 8'd10;
                "E", "e": v = 8'd11;
                "H", "h": v = 8'd12;
                "L", "l": v = 8'd13;
                "P", "p": v = 8'd14;
                default:  v = 8'd15;
            endcase
        end
        return v;
    endfunction

    function automatic t_byte to_segments(input t_byte c);
        t_byte v;
        case (c)
            "0": v = 8'h3F;
            "1": v = 8'h06;
            "2": v = 8'h5B;
            "3": v = 8'h4F;
            "4": v = 8'h66;
            "5": v = 8'h6D;
            "6": v = 8'h7D;
            "7": v = 8'h07;
            "8": v = 8'h7F;
            "9": v = 8'h6F;
            "A", "a": v = 8'h77;
            "B", "b": v = 8'h7C;
            "C", "c": v = 8'h39;
            "D", "d": v = 8'h5E;
            "E", "e": v = 8'h79;
            "F", "f": v = 8'h71;
            "G", "g": v = 8'h3D;
            "H", "h": v = 8'h76;
            "I", "i": v = 8'h06;
            "J", "j": v = 8'h0E;
            "L", "l": v = 8'h38;
            "N", "n": v = 8'h54;
            "O", "o": v = 8'h3F;
            "P", "p": v = 8'h73;
            "R", "r": v = 8'h50;
            "S", "s": v = 8'h6D;
            "T", "t": v = 8'h78;
            "U", "u": v = 8'h3E;
            "Y", "y": v = 8'h6E;
            "-": v = 8'h40;
            "_": v = 8'h08;
            "=": v = 8'h48;
            ".": v = 8'h80;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sstw_char_enc.sv]
`default_nettype none

module sstw_char_enc (
    input  var sstw_pkg::t_byte i_char,
    input  var logic            i_dp,
    input  var sstw_pkg::t_byte i_mode,
    output var sstw_pkg::t_byte o_data
);
    import sstw_pkg::*;

    t_byte w_base;

    always_comb begin
        w_base = (i_mode == CODE_B_MODE) ? to_code_b(i_char) : to_segments(i_char);
        o_data = i_dp ? (w_base | DP_BIT) : w_base;
    end

endmodule

`default_nettype wire

[hw/rtl/seven_segment_text_writer_core.sv]
// path: an input transaction loads the job register, which feeds the output register
// throughput: one write per cycle unless the output stalls; an item causing a single
// write is taken every cycle, a string start or empty string emits DIGIT_COUNT blank
// writes from a counter and holds off input until the last moves to the output register
// reset (synchronous, active low): decode mode 0xFF, no string open, no held
// character, position 1, job and output registers empty
`default_nettype none

module seven_segment_text_writer_core #(
    parameter int DIGIT_COUNT = 5
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        i_s_axis_tvalid,
    output var logic        o_s_axis_tready,
    input  var logic [23:0] i_s_axis_tdata,   // char_code[7:0], digit[10:8], pattern[18:11]
    input  var logic [1:0]  i_s_axis_tuser,   // action[1:0]
    output var logic        o_m_axis_tvalid,
    input  var logic        i_m_axis_tready,
    output var logic [15:0] o_m_axis_tdata,   // reg_addr[3:0], reg_data[11:4]
    output var logic        o_m_axis_tlast,
    input  var logic        i_cfg_valid,
    output var logic        o_cfg_ready,
    input  var logic [7:0]  i_cfg_data
);
    import sstw_pkg::*;

    localparam int PW = $clog2(DIGIT_COUNT + 2);
    localparam logic [PW-1:0] POS_ONE  = PW'(1);
    localparam logic [PW-1:0] POS_LAST = PW'(DIGIT_COUNT);

    // input fields
    logic [1:0] w_action;
    t_byte      w_char;
    logic [2:0] w_digit;
    t_byte      w_pattern;

    assign w_action  = i_s_axis_tuser;
    assign w_char    = i_s_axis_tdata[7:0];
    assign w_digit   = i_s_axis_tdata[10:8];
    assign w_pattern = i_s_axis_tdata[18:11];

    // state
    t_byte         r_mode;
    logic          r_in_string, n_in_string;
    logic          r_held_valid, n_held_valid;
    t_byte         r_held_char, n_held_char;
    logic [PW-1:0] r_pos, n_pos;

    // job register
    logic          r_job_valid;
    logic          r_job_burst;
    t_addr         r_job_addr;
    t_byte         r_job_data;
    logic [PW-1:0] r_job_cnt;

    // output register
    logic  r_out_valid;
    t_addr r_out_addr;
    t_byte r_out_data;
    logic  r_out_last;

    logic  w_accept;
    logic  w_has_write;
    logic  w_burst;
    t_addr w_addr;
    t_byte w_data;
    logic  w_dp;
    t_byte w_held_enc;
    logic  w_pos_ok;
    logic  w_out_free;
    logic  w_step;
    logic  w_job_done;
    t_byte w_blank;

    sstw_char_enc u_enc (
        .i_char (r_held_char),
        .i_dp   (w_dp),
        .i_mode (r_mode),
        .o_data (w_held_enc)
    );

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_step     = r_job_valid && w_out_free;
    assign w_job_done = w_step && (!r_job_burst || r_job_cnt == POS_LAST);
    assign o_s_axis_tready = !r_job_valid || w_job_done;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pos_ok   = r_pos <= POS_LAST;
    assign w_blank    = (r_mode == CODE_B_MODE) ? BLANK_CODE_B : BLANK_SEG;

    always_comb begin
        n_in_string  = r_in_string;
        n_held_valid = r_held_valid;
        n_held_char  = r_held_char;
        n_pos        = r_pos;
        w_has_write  = 1'b0;
        w_burst      = 1'b0;
        w_dp         = 1'b0;
        w_addr       = ADDR_W'(r_pos) + t_addr'(1);
        w_data       = w_held_enc;
        case (w_action)
            ACT_CHAR: begin
                if (!r_in_string) begin
                    w_has_write  = 1'b1;
                    w_burst      = 1'b1;
                    n_in_string  = 1'b1;
                    n_held_valid = 1'b1;
                    n_held_char  = w_char;
                    n_pos        = POS_ONE;
                end else if (r_held_valid) begin
                    w_dp        = (w_char == CHAR_DOT);
                    w_has_write = w_pos_ok;
                    if (w_pos_ok) begin
                        n_pos = r_pos + POS_ONE;
                    end
                    // a dot is folded into the held character
                    if (w_dp) begin
                        n_held_valid = 1'b0;
                    end else begin
                        n_held_char = w_char;
                    end
                end else begin
                    n_held_char  = w_char;
                    n_held_valid = 1'b1;
                end
            end
            ACT_END: begin
                if (!r_in_string) begin
                    w_has_write = 1'b1;
                    w_burst     = 1'b1;
                end else if (r_held_valid) begin
                    w_has_write = w_pos_ok;
                end
                n_in_string  = 1'b0;
                n_held_valid = 1'b0;
                n_pos        = POS_ONE;
            end
            ACT_RAW: begin
                w_has_write = (w_digit >= 3'd1) && (32'(w_digit) <= DIGIT_COUNT);
                w_addr      = ADDR_W'(w_digit) + t_addr'(1);
                w_data      = w_pattern;
            end
            default: begin
                w_has_write = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= CODE_B_MODE;
            r_in_string  <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_char  <= '0;
            r_pos        <= POS_ONE;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (w_accept) begin
                r_in_string  <= n_in_string;
                r_held_valid <= n_held_valid;
                r_held_char  <= n_held_char;
                r_pos        <= n_pos;
            end
        end
    end

    // job register: one pending write or a blanking burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (w_accept && w_has_write) begin
            r_job_valid <= 1'b1;
        end else if (w_job_done) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_has_write) begin
            r_job_burst <= w_burst;
            r_job_addr  <= w_addr;
            r_job_data  <= w_data;
            r_job_cnt   <= POS_ONE;
        end else if (w_step && r_job_burst) begin
            r_job_cnt <= r_job_cnt + POS_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            if (r_job_burst) begin
                r_out_addr <= ADDR_W'(r_job_cnt) + t_addr'(1);
                r_out_data <= w_blank;
                r_out_last <= (r_job_cnt == POS_LAST);
            end else begin
                r_out_addr <= r_job_addr;
                r_out_data <= r_job_data;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_data, r_out_addr};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[tb/sv/tb_seven_segment_text_writer_core.sv]
`default_nettype none

module tb_seven_segment_text_writer_core;
    import sstw_pkg::*;

    localparam int DIGITS = 5;
    localparam logic [1:0] ACT_IDLE = 2'd3;   // unused action, must be ignored

    typedef struct packed {
        t_addr addr;
        t_byte data;
        logic  last;
    } t_reg_write;

    // predicts the register writes of the text writer and holds them until they arrive
    class seg_write_board;
        t_byte        mode = CODE_B_MODE;
        bit           open_str;
        bit           held_ok;
        t_byte        held;
        int unsigned  pos = 1;
        t_reg_write   due[$];
        t_reg_write   batch[$];
        int unsigned  errors;

        function t_byte glyph(t_byte c);
            t_byte u;
            u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
            if (mode == CODE_B_MODE) begin
                if (c >= "0" && c <= "9") return c - "0";
                case (u)
                    "-": return 8'd10;
                    "E": return 8'd11;
                    "H": return 8'd12;
                    "L": return 8'd13;
                    "P": return 8'd14;
                    default: return 8'd15;
                endcase
            end
            case (u)
                "0", "O": return 8'b0011_1111;
                "1", "I": return 8'b0000_0110;
                "2": return 8'b0101_1011;
                "3": return 8'b0100_1111;
                "4": return 8'b0110_0110;
                "5", "S": return 8'b0110_1101;
                "6": return 8'b0111_1101;
                "7": return 8'b0000_0111;
                "8": return 8'b0111_1111;
                "9": return 8'b0110_1111;
                "A": return 8'b0111_0111;
                "B": return 8'b0111_1100;
                "C": return 8'b0011_1001;
                "D": return 8'b0101_1110;
                "E": return 8'b0111_1001;
                "F": return 8'b0111_0001;
                "G": return 8'b0011_1101;
                "H": return 8'b0111_0110;
                "J": return 8'b0000_1110;
                "L": return 8'b0011_1000;
                "N": return 8'b0101_0100;
                "P": return 8'b0111_0011;
                "R": return 8'b0101_0000;
                "T": return 8'b0111_1000;
                "U": return 8'b0011_1110;
                "Y": return 8'b0110_1110;
                "-": return 8'b0100_0000;
                "_": return 8'b0000_1000;
                "=": return 8'b0100_1000;
                ".": return 8'b1000_0000;
                default: return 8'b0000_0000;
            endcase
        endfunction

        function void add(int unsigned p, t_byte d);
            t_reg_write w;
            w.addr = t_addr'(p + 1);
            w.data = d;
            w.last = 1'b0;
            batch.push_back(w);
        endfunction

        function void blank_all();
            for (int p = 1; p <= DIGITS; p++) add(p, glyph(" "));
        endfunction

        // positions past the last digit swallow the character
        function void place_held(bit dp);
            if (pos <= DIGITS) begin
                add(pos, glyph(held) | (dp ? DP_BIT : 8'h00));
                pos++;
            end
            held_ok = 1'b0;
        endfunction

        function void note_item(logic [1:0] act, t_byte ch, logic [2:0] dig, t_byte pat);
            t_reg_write w;
            batch.delete();
            case (act)
                ACT_CHAR: begin
                    if (!open_str) begin
                        blank_all();
                        open_str = 1'b1;
                        held_ok  = 1'b0;
                        pos      = 1;
                    end
                    if (held_ok && ch == CHAR_DOT) begin
                        place_held(1'b1);
                    end else begin
                        if (held_ok) place_held(1'b0);
                        held    = ch;
                        held_ok = 1'b1;
                    end
                end
                ACT_END: begin
                    if (!open_str) blank_all();
                    else if (held_ok) place_held(1'b0);
                    open_str = 1'b0;
                    held_ok  = 1'b0;
                    pos      = 1;
                end
                ACT_RAW: begin
                    if (dig >= 1 && dig <= DIGITS) add(dig, pat);
                end
                default: ;
            endcase
            for (int i = 0; i < batch.size(); i++) begin
                w = batch[i];
                w.last = (i == batch.size() - 1);
                due.push_back(w);
            end
        endfunction

        function void check_write(t_addr a, t_byte d, logic l);
            t_reg_write w;
            if (due.size() == 0) begin
                $error("unexpected write: reg_addr %0d reg_data %02h", a, d);
                errors++;
                return;
            end
            w = due.pop_front();
            if (w.addr !== a) begin
                $error("reg_addr: expected %0d, actual %0d", w.addr, a);
                errors++;
            end
            if (w.data !== d) begin
                $error("reg_data: expected %02h, actual %02h", w.data, d);
                errors++;
            end
            if (w.last !== l) begin
                $error("last_of_run: expected %0b, actual %0b", w.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data = '0;
    wire         s_ready;
    wire         m_valid;
    wire  [15:0] m_data;
    wire         m_last;
    wire         cfg_ready;

    seg_write_board sb = new;
    bit          offering;
    bit          calm;
    bit          hold_req;
    int unsigned items_sent;

    seven_segment_text_writer_core #(.DIGIT_COUNT(DIGITS)) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // char_code[7:0], digit[10:8], pattern[18:11]
        .i_s_axis_tuser  (s_user),    // action[1:0]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // reg_addr[3:0], reg_data[11:4]
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("tb_seven_segment_text_writer_core: done, errors");
        $finish;
    end

    // handshakes are sampled at the falling edge, all inputs change at the rising edge
    initial begin
        forever begin
            @(negedge clk);
            if (rst_n && m_valid && m_ready) sb.check_write(m_data[3:0], m_data[11:4], m_last);
        end
    end

    initial begin
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (90) @(posedge clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic t_byte pick_char();
        string letters;
        letters = "AaBbCcDdEeFfGgHhIiJjLlNnOoPpRrSsTtUuYy-_=KkMQVWXZ";
        case ($urandom_range(0, 11))
            0, 1, 2: return t_byte'("0" + $urandom_range(0, 9));
            3, 4:    return CHAR_DOT;
            5, 6:    return t_byte'(letters[$urandom_range(0, letters.len() - 1)]);
            7:       return " ";
            8:       return 8'h00;
            9:       return 8'hFF;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic stop_stream();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_item(logic [1:0] act, t_byte ch, logic [2:0] dig, t_byte pat);
        if (!calm && $urandom_range(0, 6) == 0) begin
            stop_stream();
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_valid <= 1'b1;
        offering = 1'b1;
        s_data  <= {5'b0, pat, dig, ch};
        s_user  <= act;
        do @(negedge clk); while (!s_ready);
        @(posedge clk);
        sb.note_item(act, ch, dig, pat);
        items_sent++;
    endtask

    task automatic send_char(t_byte ch);
        send_item(ACT_CHAR, ch, 3'($urandom_range(0, 7)), t_byte'($urandom_range(0, 255)));
    endtask

    task automatic send_end();
        send_item(ACT_END, t_byte'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  t_byte'($urandom_range(0, 255)));
    endtask

    task automatic send_raw(logic [2:0] dig, t_byte pat);
        send_item(ACT_RAW, t_byte'($urandom_range(0, 255)), dig, pat);
    endtask

    task automatic send_idle();
        send_item(ACT_IDLE, t_byte'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  t_byte'($urandom_range(0, 255)));
    endtask

    // dropped characters and ignored items leave no write behind, so the task waits on
    // past the last expected write before touching the mode
    task automatic write_mode(t_byte v);
        stop_stream();
        while (sb.due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.mode = v;
    endtask

    task automatic random_string();
        int unsigned len;
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 11))
                0:       send_raw(3'($urandom_range(0, 7)), t_byte'($urandom_range(0, 255)));
                1:       send_idle();
                default: send_char(pick_char());
            endcase
        end
        // now and then the string stays open and the next one runs on
        if ($urandom_range(0, 9) != 0) send_end();
    endtask

    task automatic random_until(int unsigned target);
        while (items_sent < target) random_string();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // code b after reset: empty string, dots, full display, odd characters, raw writes, an ignored item
        send_end();
        send_char("8");
        send_char(".");
        send_char(".");
        send_char("-");
        send_char("E");
        send_char("h");
        send_char("L");
        send_char("p");
        send_char(8'h00);
        send_end();
        send_char(8'hFF);
        send_char(".");
        send_char(8'h00);
        send_end();
        send_raw(3'd0, 8'hFF);
        send_raw(3'd1, 8'h00);
        send_raw(3'd5, 8'hFF);
        send_raw(3'd6, 8'h55);
        send_raw(3'd7, 8'hAA);
        send_idle();
        send_end();

        write_mode(8'h00);
        send_char("A");
        send_char(".");
        send_char(".");
        send_end();

        write_mode(8'hFF);
        hold_req = 1'b1;
        random_until(120);
        write_mode(8'h00);
        random_until(200);
        write_mode(t_byte'($urandom_range(1, 254)));
        random_until(270);
        stop_stream();
        calm = 1'b1;
        write_mode(8'hFE);
        random_until(335);

        stop_stream();
        while (sb.due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0) begin
            $display("tb_seven_segment_text_writer_core: done, clean");
        end else begin
            $display("tb_seven_segment_text_writer_core: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
